// ===== src/bssc_pkg.sv =====
// ----------------------------------------------------------------------------
// bssc_pkg: shared types and constants
// Opcodes, outcome codes, controller states and the cell command for the
// sorted sequence collector.
// ----------------------------------------------------------------------------
package bssc_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int SEQ_W     = 64;
   localparam int PAY_W     = 64;
   localparam int IDX_W     = 4;
   localparam int HELD_W    = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_START  = 2'd1,
      OP_DRAIN  = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      OC_INSERTED = 3'd0,
      OC_BELOW    = 3'd1,
      OC_DUP      = 3'd2,
      OC_DROPPED  = 3'd3,
      OC_EVICTED  = 3'd4,
      OC_ENTRY    = 3'd5,
      OC_EMPTY    = 3'd6
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_INS,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CMP,
      CELL_INS,
      CELL_ROT
   } cell_op_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [PAY_W-1:0] pay;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   key;
   } cell_cmd_type;

endpackage

// ===== src/bounded_sorted_sequence_collector.sv =====
// ----------------------------------------------------------------------------
// bounded_sorted_sequence_collector: sorted insertion buffer
// Keeps the DEPTH smallest distinct sequence numbers above a cursor, with
// payloads, in a chain of slots kept in ascending order.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser       | tlast
//  req_    | in  | seq_number[63:0] record_payload[127:64]| opcode[1:0] | -
//  rsp_    | out | entry_index[3:0] entry_seq[67:4]       | outcome[2:0]| last
//          |     | entry_payload[131:68] held_count[136:132]|           |
//          |     | more_flag[137]                         |             |
//
//  Insert: accept, slot compare, chain update; the per-slot compare is
//  registered ahead of the shift.
//  Drain: accept, then one entry per cycle while the output register is free,
//  as the chain rotates through slot zero. Start and no-op finish on accept.
//  A new request is taken only while the controller is idle; a stalled result
//  holds the chain until the output register frees. Reset is synchronous and
//  clears count, flag, cursor and the output valid.
// ----------------------------------------------------------------------------
module bounded_sorted_sequence_collector #(
   parameter int DEPTH = bssc_pkg::DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // seq_number, record_payload
   input  logic [1:0]    req_tuser,   // opcode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,   // entry_index, entry_seq, entry_payload,
                                      // held_count, more_flag, zero pad
   output logic [2:0]    rsp_tuser,   // outcome
   output logic          rsp_tlast
);
   import bssc_pkg::*;

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int IdxW = $clog2(DEPTH);

   state_type        state_ff, state_in;
   entry_type        key_ff, key_in;
   logic [SEQ_W-1:0] cursor_ff, cursor_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             below_ff, below_in;
   logic [IdxW-1:0]  idx_ff, idx_in;

   logic             rsp_valid_ff;
   outcome_type      oc_ff, oc_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   entry_type        oent_ff, oent_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic             more_ff, more_in;
   logic             last_ff, last_in;
   logic             out_load;
   logic             out_free;

   cell_cmd_type     cmd;
   entry_type        cell_entry [DEPTH];
   logic [DEPTH-1:0] lt_vec, eq_vec, live_vec, wrap_vec;
   logic [CntW-1:0]  cnt_last;
   logic [CntW+HELD_W-1:0] held_ext;
   logic [IdxW+IDX_W-1:0]  idx_ext;
   logic             full, dup, drop, drain_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cnt_last   = count_ff - CntW'(1);
   assign full       = (count_ff == CntW'(DEPTH));
   assign dup        = |eq_vec;
   assign drop       = full && lt_vec[DEPTH-1];
   assign drain_last = (CntW'(idx_ff) == cnt_last);
   assign held_ext   = {{HELD_W{1'b0}}, count_in};
   assign idx_ext    = {{IDX_W{1'b0}}, idx_ff};

   // ---- slot chain ----
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign live_vec[i] = (CntW'(i) < count_ff);
      assign wrap_vec[i] = (CntW'(i) == cnt_last);

      bssc_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .live       (live_vec[i]),
         .wrap_here  (wrap_vec[i]),
         .prev_lt    ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i-1]),
         .prev_entry (cell_entry[(i == 0) ? 0 : i-1]),
         .next_entry (cell_entry[(i == DEPTH-1) ? i : i+1]),
         .head_entry (cell_entry[0]),
         .entry      (cell_entry[i]),
         .lt         (lt_vec[i]),
         .eq         (eq_vec[i])
      );
   end

   // ---- controller ----
   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      cursor_in  = cursor_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      below_in   = below_ff;
      idx_in     = idx_ff;
      cmd.op     = CELL_HOLD;
      cmd.key    = key_ff;
      req_tready = 1'b0;
      out_load   = 1'b0;
      oc_in      = OC_INSERTED;
      oidx_in    = '0;
      oent_in    = '0;
      last_in    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in.seq = req_tdata[SEQ_W-1:0];
               key_in.pay = req_tdata[SEQ_W+PAY_W-1:SEQ_W];
               unique case (opcode_type'(req_tuser))
                  OP_INSERT: state_in = ST_CMP;
                  OP_START: begin
                     count_in  = '0;
                     ovf_in    = 1'b0;
                     cursor_in = req_tdata[SEQ_W-1:0];
                  end
                  OP_DRAIN: begin
                     idx_in   = '0;
                     state_in = ST_DRAIN;
                  end
                  OP_NOP: ;
                  default: ;
               endcase
            end
         end
         ST_CMP: begin
            cmd.op   = CELL_CMP;
            below_in = (key_ff.seq <= cursor_ff);
            state_in = ST_INS;
         end
         ST_INS: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               priority if (below_ff) begin
                  oc_in = OC_BELOW;
               end else if (dup) begin
                  oc_in = OC_DUP;
               end else if (drop) begin
                  ovf_in = 1'b1;
                  oc_in  = OC_DROPPED;
               end else begin
                  cmd.op = CELL_INS;
                  if (full) begin
                     ovf_in = 1'b1;
                     oc_in  = OC_EVICTED;
                  end else begin
                     count_in = count_ff + CntW'(1);
                     oc_in    = OC_INSERTED;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               out_load = 1'b1;
               if (count_ff == '0) begin
                  oc_in    = OC_EMPTY;
                  state_in = ST_IDLE;
               end else begin
                  // slot zero goes out and wraps to the last live slot
                  cmd.op  = CELL_ROT;
                  oc_in   = OC_ENTRY;
                  oidx_in = idx_ext[IDX_W-1:0];
                  oent_in = cell_entry[0];
                  last_in = drain_last;
                  idx_in  = idx_ff + IdxW'(1);
                  if (drain_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      held_in = held_ext[HELD_W-1:0];
      more_in = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      below_ff <= below_in;
      idx_ff   <= idx_in;
      if (out_load) begin
         oc_ff   <= oc_in;
         oidx_ff <= oidx_in;
         oent_ff <= oent_in;
         held_ff <= held_in;
         more_ff <= more_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = oc_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'd0, more_ff, held_ff, oent_ff.pay, oent_ff.seq, oidx_ff};

endmodule

// ===== src/bssc_cell.sv =====
// ----------------------------------------------------------------------------
// bssc_cell: one slot of the sorted chain
// Holds one entry, compares it against the key, and on insert either keeps
// its entry, takes the key, or takes its lower neighbor's entry. On drain the
// chain rotates toward slot zero.
// ----------------------------------------------------------------------------
module bssc_cell (
   input  logic                  clock,
   input  bssc_pkg::cell_cmd_type cmd,
   input  logic                  live,       // slot holds a stored entry
   input  logic                  wrap_here,  // last live slot: takes the head on rotate
   input  logic                  prev_lt,
   input  bssc_pkg::entry_type   prev_entry,
   input  bssc_pkg::entry_type   next_entry,
   input  bssc_pkg::entry_type   head_entry,
   output bssc_pkg::entry_type   entry,
   output logic                  lt,
   output logic                  eq
);
   import bssc_pkg::*;

   entry_type entry_ff, entry_in;
   logic      lt_ff, lt_in;
   logic      eq_ff, eq_in;

   always_comb begin
      entry_in = entry_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      unique case (cmd.op)
         CELL_HOLD: ;
         CELL_CMP: begin
            lt_in = live && (entry_ff.seq < cmd.key.seq);
            eq_in = live && (entry_ff.seq == cmd.key.seq);
         end
         CELL_INS: begin
            // entries below the key stay; the first slot above takes the key
            if (!lt_ff) begin
               entry_in = prev_lt ? cmd.key : prev_entry;
            end
         end
         CELL_ROT: begin
            entry_in = wrap_here ? head_entry : next_entry;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// ===== src/bssc_checker.sv =====
// ----------------------------------------------------------------------------
// bssc_checker: port-level checks for the sequence collector
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module bssc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast
);
   import bssc_pkg::*;

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // only drained entries can be non-final
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != OC_ENTRY) |-> rsp_tlast)
      else $error("single result without last");

   // a drained entry implies a non-empty batch
   a_entry_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == OC_ENTRY) |-> (rsp_tdata[136:132] != 5'd0))
      else $error("entry drained from empty batch");

   // mid-drain, no new request is taken
   a_drain_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during drain");

endmodule

bind bounded_sorted_sequence_collector bssc_checker u_bssc_checker (.*);

// ===== tb/tb_bounded_sorted_sequence_collector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_sorted_sequence_collector: self-checking bench
// Drives insert, start, drain and no-op requests, predicts every response
// from an independent copy of the sorted batch, and compares each response
// field by field, under random idling on both stream channels, then with none.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_sequence_collector;
   import bssc_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic [2:0]        outcome;
      logic [IDX_W-1:0]  index;
      logic [SEQ_W-1:0]  seq;
      logic [PAY_W-1:0]  pay;
      logic [HELD_W-1:0] held;
      logic              more;
      logic              last;
   } collector_rsp_type;

   class batch_scoreboard_type;
      localparam int SLOTS = DEPTH_DEF;

      logic [SEQ_W-1:0]  seqs [SLOTS];
      logic [PAY_W-1:0]  pays [SLOTS];
      int                held;
      bit                overflow;
      logic [SEQ_W-1:0]  cursor;
      collector_rsp_type pending_results [$];
      int                mismatches;

      function new();
         held       = 0;
         overflow   = 0;
         cursor     = '0;
         mismatches = 0;
      endfunction

      task flag_mismatch(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function collector_rsp_type make_rsp(logic [2:0] oc, int idx, logic [SEQ_W-1:0] s,
                                           logic [PAY_W-1:0] p, bit fin);
         collector_rsp_type r;
         r.outcome = oc;
         r.index   = idx[IDX_W-1:0];
         r.seq     = s;
         r.pay     = p;
         r.held    = held[HELD_W-1:0];
         r.more    = overflow;
         r.last    = fin;
         return r;
      endfunction

      function logic [2:0] place_record(logic [SEQ_W-1:0] s, logic [PAY_W-1:0] p);
         int pos;
         int top;
         if (s <= cursor) return OC_BELOW;
         pos = 0;
         while (pos < held && seqs[pos] < s) pos++;
         if (pos < held && seqs[pos] == s) return OC_DUP;
         if (held >= SLOTS && pos >= held) begin
            overflow = 1;
            return OC_DROPPED;
         end
         // full batch: the largest entry falls off the top slot
         top = (held < SLOTS) ? held : SLOTS - 1;
         for (int i = top; i > pos; i--) begin
            seqs[i] = seqs[i-1];
            pays[i] = pays[i-1];
         end
         seqs[pos] = s;
         pays[pos] = p;
         if (held < SLOTS) begin
            held++;
            return OC_INSERTED;
         end
         overflow = 1;
         return OC_EVICTED;
      endfunction

      function void take_request(logic [1:0] op, logic [SEQ_W-1:0] s,
                                 logic [PAY_W-1:0] p);
         logic [2:0] oc;
         case (op)
            OP_INSERT: begin
               oc = place_record(s, p);
               pending_results.push_back(make_rsp(oc, 0, '0, '0, 1'b1));
            end
            OP_START: begin
               held     = 0;
               overflow = 0;
               cursor   = s;
            end
            OP_DRAIN: begin
               if (held == 0)
                  pending_results.push_back(make_rsp(OC_EMPTY, 0, '0, '0, 1'b1));
               else
                  for (int i = 0; i < held; i++)
                     pending_results.push_back(make_rsp(OC_ENTRY, i, seqs[i], pays[i],
                                                        i + 1 == held));
            end
            default: ;
         endcase
      endfunction

      task match_response(collector_rsp_type got);
         collector_rsp_type want;
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected response outcome=%0d seq=%h",
                                    got.outcome, got.seq));
            return;
         end
         want = pending_results.pop_front();
         if (got.outcome !== want.outcome)
            flag_mismatch($sformatf("outcome got %0d want %0d", got.outcome, want.outcome));
         if (got.index !== want.index)
            flag_mismatch($sformatf("entry_index got %0d want %0d", got.index, want.index));
         if (got.seq !== want.seq)
            flag_mismatch($sformatf("entry_seq got %h want %h", got.seq, want.seq));
         if (got.pay !== want.pay)
            flag_mismatch($sformatf("entry_payload got %h want %h", got.pay, want.pay));
         if (got.held !== want.held)
            flag_mismatch($sformatf("held_count got %0d want %0d", got.held, want.held));
         if (got.more !== want.more)
            flag_mismatch($sformatf("more_flag got %b want %b", got.more, want.more));
         if (got.last !== want.last)
            flag_mismatch($sformatf("last got %b want %b", got.last, want.last));
      endtask
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;   // seq_number[63:0], record_payload[127:64]
   logic [1:0]   req_tuser  = OP_NOP;  // opcode[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;   // entry_index[3:0], entry_seq[67:4], entry_payload[131:68],
                              // held_count[136:132], more_flag[137], zero pad
   logic [2:0]   rsp_tuser;   // outcome[2:0]
   logic         rsp_tlast;

   int send_idle_pct = 26;
   int recv_idle_pct = 54;
   int quiet_cycles  = 0;

   batch_scoreboard_type board = new();

   bounded_sorted_sequence_collector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // request and response monitor
   always @(posedge clock) begin
      collector_rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.take_request(req_tuser, req_tdata[63:0], req_tdata[127:64]);
         if (rsp_tvalid && rsp_tready) begin
            got.outcome = rsp_tuser;
            got.index   = rsp_tdata[3:0];
            got.seq     = rsp_tdata[67:4];
            got.pay     = rsp_tdata[131:68];
            got.held    = rsp_tdata[136:132];
            got.more    = rsp_tdata[137];
            got.last    = rsp_tlast;
            board.match_response(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[bounded_sorted_sequence_collector] ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_request(opcode_type op, logic [63:0] s, logic [63:0] p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {p, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic run_directed();
      send_request(OP_DRAIN, '0, '0);             // empty batch
      send_request(OP_INSERT, '0, rand64());      // zero is at the reset cursor
      send_request(OP_NOP, '1, '1);
      send_request(OP_INSERT, '1, '1);
      send_request(OP_INSERT, '1, '0);            // duplicate
      for (int s = 16; s >= 2; s--)               // descending fills the batch
         send_request(OP_INSERT, 64'(s), rand64());
      send_request(OP_INSERT, 64'd1, rand64());   // full: pushes out the largest
      send_request(OP_INSERT, 64'd17, rand64());  // full and above every entry
      send_request(OP_DRAIN, rand64(), rand64());
      send_request(OP_START, '1, rand64());
      send_request(OP_INSERT, 64'd5, rand64());   // below the top cursor
      send_request(OP_DRAIN, '0, '0);
      send_request(OP_START, '0, '1);
   endtask

   task automatic run_random(int count);
      int sent;
      int roll;
      logic [63:0] cur;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 3))
            0: cur = '0;
            1: cur = 64'($urandom_range(0, 1000));
            2: cur = rand64();
            default: cur = '1 - 64'($urandom_range(0, 20));
         endcase
         send_request(OP_START, cur, rand64());
         sent++;
         repeat ($urandom_range(4, 28)) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
               send_request(OP_DRAIN, rand64(), rand64());
            else if (roll < 11)
               send_request(OP_NOP, rand64(), rand64());
            else if (roll < 19)
               send_request(OP_INSERT, rand64(), rand64());
            else if (roll < 25)
               send_request(OP_INSERT, cur - 64'($urandom_range(0, 3)), rand64());
            else
               send_request(OP_INSERT, cur + 64'($urandom_range(1, 24)), rand64());
            sent++;
         end
         send_request(OP_DRAIN, rand64(), rand64());
         sent++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(75);
      send_idle_pct = 54;
      recv_idle_pct = 26;
      run_random(75);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(75);
      req_tvalid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.mismatches == 0)
         $display("[bounded_sorted_sequence_collector] OK");
      else
         $display("[bounded_sorted_sequence_collector] ERROR");
      $finish;
   end

endmodule
